[hw/rtl/spq_pkg.sv]
// Shared definitions for the stable priority queue: default sizes,
// operation and status codes. No dependencies.
package spq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int ID_BITS_DEF  = 8;
  localparam int PRI_BITS_DEF = 8;
  localparam int OP_BITS      = 2;
  localparam int ST_BITS      = 2;
  localparam int OCC_BITS     = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CHANGE = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [ST_BITS-1:0] {
    ST_DONE      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

[hw/rtl/stable_priority_queue_with_rekey.sv]
// Stable priority queue with re-keying; sorted slots in one RAM (spq_ram),
// results through spq_out_reg; codes from spq_pkg.
// A pop runs the removal scan; a change runs it, then the insertion walk; an insert
// walks (or writes slot 0 of an empty queue). Refused, empty or unused-code requests
// go straight to the result. One request at a time: the next is taken after the
// result loads. Reset empties the queue; slots stay undefined.
module stable_priority_queue_with_rekey
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int ID_BITS       = ID_BITS_DEF,
  parameter int PRIORITY_BITS = PRI_BITS_DEF,
  localparam int IN_DW  = ((ID_BITS + PRIORITY_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((ID_BITS + PRIORITY_BITS + OCC_BITS + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_DW-1:0]    s_axis_tdata,   // entry_id, entry_priority
  input  logic [OP_BITS-1:0]  s_axis_tuser,   // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_DW-1:0]   m_axis_tdata,   // served_id, served_priority, occupancy
  output logic [ST_BITS-1:0]  m_axis_tuser    // status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_BITS + PRIORITY_BITS;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_REM  = 5'b00010,
    S_INS  = 5'b00100,
    S_PUT  = 5'b01000,
    S_RES  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [OP_BITS-1:0]   op_q, op_d;
  logic [ID_BITS-1:0]   id_q, id_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic [CW-1:0]        pidx_q, pidx_d;
  logic                 pend_q, pend_d;
  logic                 found_q, found_d;
  logic [EW-1:0]        served_q, served_d;
  status_e              status_q, status_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;
  logic [ID_BITS-1:0]   rd_id;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic                 match, last, issue;
  logic [CW-1:0]        waddr_full;

  logic                 out_free, out_load;
  logic [OUT_DW-1:0]    res_data;
  logic [EW-1:0]        res_served;

  assign rd_id  = ram_rdata[ID_BITS-1:0];
  assign rd_pri = ram_rdata[EW-1:ID_BITS];
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    id_d       = id_q;
    pri_d      = pri_q;
    cnt_d      = cnt_q;
    rd_idx_d   = rd_idx_q;
    pidx_d     = pidx_q;
    pend_d     = 1'b0;
    found_d    = found_q;
    served_d   = served_q;
    status_d   = status_q;
    ram_we     = 1'b0;
    waddr_full = '0;
    ram_wdata  = ram_rdata;
    ram_raddr  = rd_idx_q[AW-1:0];
    out_load   = 1'b0;
    match      = 1'b0;
    last       = 1'b0;
    issue      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d     = s_axis_tuser;
          id_d     = s_axis_tdata[ID_BITS-1:0];
          pri_d    = s_axis_tdata[EW-1:ID_BITS];
          found_d  = 1'b0;
          served_d = '0;
          status_d = ST_DONE;
          rd_idx_d = '0;
          case (s_axis_tuser)
            OP_INSERT: begin
              if (cnt_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_RES;
              end else if (cnt_q == '0) begin
                state_d = S_PUT;
              end else begin
                rd_idx_d = cnt_q - 1'b1;
                state_d  = S_INS;
              end
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_RES;
              end else begin
                state_d = S_REM;
              end
            end
            OP_CHANGE: begin
              if (cnt_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_RES;
              end else begin
                state_d = S_REM;
              end
            end
            default: state_d = S_RES;
          endcase
        end
      end

      // Scan from the front; once the victim is found, move each later slot down one.
      S_REM: begin
        issue  = (rd_idx_q < cnt_q);
        pidx_d = rd_idx_q;
        if (issue) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
        if (pend_q) begin
          match = (op_q == OP_POP) ? (pidx_q == '0) : (rd_id == id_q);
          last  = (pidx_q == cnt_q - 1'b1);
          if (found_q) begin
            ram_we     = 1'b1;
            waddr_full = pidx_q - 1'b1;
          end else if (match) begin
            found_d  = 1'b1;
            served_d = ram_rdata;
          end
          if (last) begin
            if (found_q || match) begin
              cnt_d = cnt_q - 1'b1;
              if (op_q == OP_POP) begin
                state_d = S_RES;
              end else if (cnt_q == CW'(1)) begin
                state_d = S_PUT;
              end else begin
                rd_idx_d = cnt_q - CW'(2);
                state_d  = S_INS;
              end
            end else begin
              status_d = ST_NOT_FOUND;
              state_d  = S_RES;
            end
          end
        end
        pend_d = issue && !last;
      end

      // Walk from the back, shifting lower-priority slots up one until the spot opens.
      S_INS: begin
        pidx_d = rd_idx_q;
        pend_d = 1'b1;
        if (rd_idx_q != '0) begin
          rd_idx_d = rd_idx_q - 1'b1;
        end
        if (pend_q) begin
          ram_we     = 1'b1;
          waddr_full = pidx_q + 1'b1;
          if (rd_pri >= pri_q) begin
            ram_wdata = {pri_q, id_q};
            cnt_d     = cnt_q + 1'b1;
            state_d   = S_RES;
            pend_d    = 1'b0;
          end else if (pidx_q == '0) begin
            state_d = S_PUT;
            pend_d  = 1'b0;
          end
        end
      end

      S_PUT: begin
        ram_we     = 1'b1;
        waddr_full = '0;
        ram_wdata  = {pri_q, id_q};
        cnt_d      = cnt_q + 1'b1;
        state_d    = S_RES;
      end

      S_RES: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign ram_waddr = waddr_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    pri_q    <= pri_d;
    rd_idx_q <= rd_idx_d;
    pidx_q   <= pidx_d;
    served_q <= served_d;
    status_q <= status_d;
  end

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Only a successful pop reports the removed entry.
  assign res_served = (op_q == OP_POP && status_q == ST_DONE) ? served_q : '0;
  assign res_data   = OUT_DW'({OCC_BITS'(cnt_q), res_served[EW-1:ID_BITS],
                               res_served[ID_BITS-1:0]});

  spq_out_reg #(
    .DW (OUT_DW),
    .UW (ST_BITS)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .data_i        (res_data),
    .user_i        (status_q),
    .free_o        (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("slot write while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != S_IDLE))
    else $error("transaction accepted without leaving idle");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_q == ST_FULL) |-> (cnt_q == CW'(DEPTH)))
    else $error("full status with free slots");

endmodule

[hw/rtl/spq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/spq_out_reg.sv]
// Output register of the queue: holds one finished result until the
// downstream side takes it. No dependencies.
module spq_out_reg #(
  parameter int DW = 24,
  parameter int UW = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic [DW-1:0] data_i,
  input  logic [UW-1:0] user_i,
  output logic          free_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [DW-1:0] m_axis_tdata,
  output logic [UW-1:0] m_axis_tuser
);

  logic          valid_q, valid_d;
  logic [DW-1:0] data_q;
  logic [UW-1:0] user_q;

  assign free_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
      user_q <= user_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for stable_priority_queue_with_rekey: drives random and
// directed requests, predicts each response from a sorted shadow store and checks it.
// Depends on spq_pkg and the queue RTL.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  localparam int DEPTH  = DEPTH_DEF;
  localparam int IDW    = ID_BITS_DEF;
  localparam int PRIW   = PRI_BITS_DEF;
  localparam int IN_DW  = ((IDW + PRIW + 7) / 8) * 8;
  localparam int OUT_DW = ((IDW + PRIW + OCC_BITS + 7) / 8) * 8;
  localparam int NUM_RANDOM = 1750;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic [IDW-1:0]     id;
    logic [PRIW-1:0]    pri;
  } request_t;

  typedef struct packed {
    status_e             status;
    logic [IDW-1:0]      id;
    logic [PRIW-1:0]     pri;
    logic [OCC_BITS-1:0] occupancy;
  } response_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_DW-1:0]    s_axis_tdata  = '0;  // entry_id, entry_priority
  logic [OP_BITS-1:0]  s_axis_tuser  = '0;  // operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_DW-1:0]   m_axis_tdata;        // served_id, served_priority, occupancy
  logic [ST_BITS-1:0]  m_axis_tuser;        // status

  request_t  request_queue[$];
  response_t awaited_responses[$];

  // Shadow of the sorted store, front at index 0
  logic [IDW-1:0]  shadow_ids[DEPTH];
  logic [PRIW-1:0] shadow_pris[DEPTH];
  int              shadow_count = 0;

  int  error_count = 0;
  int  send_gap    = 0;
  int  stall_cnt   = 0;
  bit  quiet_in    = 1'b0;
  bit  quiet_out   = 1'b0;
  request_t next_req;
  response_t got;

  stable_priority_queue_with_rekey u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_ids[i]  = shadow_ids[i + 1];
      shadow_pris[i] = shadow_pris[i + 1];
    end
    shadow_count--;
  endfunction

  // Place behind every entry of equal or higher priority
  function automatic void place_entry(logic [IDW-1:0] id, logic [PRIW-1:0] pri);
    int pos;
    pos = 0;
    while (pos < shadow_count && shadow_pris[pos] >= pri) pos++;
    for (int i = shadow_count; i > pos; i--) begin
      shadow_ids[i]  = shadow_ids[i - 1];
      shadow_pris[i] = shadow_pris[i - 1];
    end
    shadow_ids[pos]  = id;
    shadow_pris[pos] = pri;
    shadow_count++;
  endfunction

  function automatic response_t compute_response(request_t req);
    response_t r;
    int pos;
    r.status = ST_DONE;
    r.id     = '0;
    r.pri    = '0;
    case (req.op)
      OP_INSERT: begin
        if (shadow_count >= DEPTH) r.status = ST_FULL;
        else place_entry(req.id, req.pri);
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id  = shadow_ids[0];
          r.pri = shadow_pris[0];
          drop_slot(0);
        end
      end
      OP_CHANGE: begin
        pos = 0;
        while (pos < shadow_count && shadow_ids[pos] != req.id) pos++;
        if (pos >= shadow_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          drop_slot(pos);
          place_entry(req.id, req.pri);
        end
      end
      default: ;  // unused code: no change
    endcase
    r.occupancy = shadow_count[OCC_BITS-1:0];
    return r;
  endfunction

  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      error_count++;
    end
  endtask

  task automatic add_request(logic [OP_BITS-1:0] op, logic [IDW-1:0] id,
                             logic [PRIW-1:0] pri);
    request_t req;
    req.op  = op;
    req.id  = id;
    req.pri = pri;
    request_queue.push_back(req);
  endtask

  // Driver: predict on each accepted transaction, then present the next request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_gap       = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        awaited_responses.push_back(compute_response(
          '{op: s_axis_tuser, id: s_axis_tdata[IDW-1:0],
            pri: s_axis_tdata[IDW+PRIW-1:IDW]}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          next_req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DW'({next_req.pri, next_req.id});
          s_axis_tuser  <= next_req.op;
          if ($urandom_range(0, 149) == 0) quiet_in = ~quiet_in;
          send_gap = quiet_in ? 0 : draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted response with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_responses.size() == 0) begin
          $error("unexpected response transaction: status %0d", m_axis_tuser);
          error_count++;
        end else begin
          got = awaited_responses.pop_front();
          check_field("status", got.status, m_axis_tuser);
          check_field("served_id", got.id, m_axis_tdata[IDW-1:0]);
          check_field("served_priority", got.pri, m_axis_tdata[IDW+PRIW-1:IDW]);
          check_field("occupancy", got.occupancy,
                      m_axis_tdata[IDW+PRIW+OCC_BITS-1:IDW+PRIW]);
        end
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 149) == 0) quiet_out = ~quiet_out;
        if (!quiet_out && $urandom_range(0, 3) == 0) stall_cnt = draw_gap();
      end
    end
  end

  initial begin
    int mode;
    int roll;
    logic [OP_BITS-1:0] op;
    logic [IDW-1:0]     id;
    logic [PRIW-1:0]    pri;

    // Directed: empty-queue cases, unused code, ties, duplicates, full queue
    add_request(OP_POP, 8'd9, 8'd9);
    add_request(OP_CHANGE, 8'd3, 8'd50);
    add_request(OP_UNUSED, 8'hff, 8'hff);
    add_request(OP_INSERT, 8'd0, 8'd0);
    add_request(OP_INSERT, 8'd255, 8'd255);
    add_request(OP_INSERT, 8'd5, 8'd255);
    add_request(OP_INSERT, 8'd7, 8'd0);
    add_request(OP_INSERT, 8'd5, 8'd100);
    add_request(OP_CHANGE, 8'd5, 8'd255);   // first copy of a duplicate
    add_request(OP_CHANGE, 8'd255, 8'd255); // same priority still moves back
    add_request(OP_CHANGE, 8'd200, 8'd1);
    add_request(OP_POP, 8'd0, 8'd0);
    for (int i = 0; i < 12; i++) add_request(OP_INSERT, 8'(16 + i), 8'd128);
    add_request(OP_INSERT, 8'd99, 8'd200);  // refused when full
    add_request(OP_CHANGE, 8'd7, 8'd1);
    add_request(OP_UNUSED, 8'h5a, 8'ha5);

    // Random: fill, drain and balanced phases to swing between empty and full
    mode = 2;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 60 == 0) mode = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      case (mode)
        0: op = roll < 65 ? OP_INSERT : roll < 80 ? OP_POP : roll < 98 ? OP_CHANGE : OP_UNUSED;
        1: op = roll < 15 ? OP_INSERT : roll < 80 ? OP_POP : roll < 98 ? OP_CHANGE : OP_UNUSED;
        default: op = roll < 40 ? OP_INSERT : roll < 75 ? OP_POP
                                            : roll < 98 ? OP_CHANGE : OP_UNUSED;
      endcase
      id  = ($urandom_range(0, 99) < 85) ? IDW'($urandom_range(0, 15))
                                         : IDW'($urandom_range(0, 255));
      pri = ($urandom_range(0, 99) < 60) ? PRIW'($urandom_range(0, 7))
                                         : PRIW'($urandom_range(0, 255));
      add_request(op, id, pri);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (request_queue.size() == 0 && !s_axis_tvalid);
    wait (awaited_responses.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && awaited_responses.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
